>>> hw/rtl/rpn_pkg.sv
package rpn_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 64;
    localparam int unsigned WORD_WIDTH_DEF  = 32;

    // operation codes
    localparam logic [4:0] MD_PUSH_INT = 5'd0;
    localparam logic [4:0] MD_TRUE     = 5'd1;
    localparam logic [4:0] MD_FALSE    = 5'd2;
    localparam logic [4:0] MD_PRINT    = 5'd3;
    localparam logic [4:0] MD_CLEAR    = 5'd4;
    localparam logic [4:0] MD_DROP     = 5'd5;
    localparam logic [4:0] MD_DUP      = 5'd6;
    localparam logic [4:0] MD_SWAP     = 5'd7;
    localparam logic [4:0] MD_ADD      = 5'd8;
    localparam logic [4:0] MD_SUB      = 5'd9;
    localparam logic [4:0] MD_MUL      = 5'd10;
    localparam logic [4:0] MD_DIV      = 5'd11;
    localparam logic [4:0] MD_MOD      = 5'd12;
    localparam logic [4:0] MD_LT       = 5'd13;
    localparam logic [4:0] MD_LE       = 5'd14;
    localparam logic [4:0] MD_GT       = 5'd15;
    localparam logic [4:0] MD_GE       = 5'd16;
    localparam logic [4:0] MD_EQ       = 5'd17;
    localparam logic [4:0] MD_NOT      = 5'd18;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NOT_INT  = 3'd2;
    localparam logic [2:0] ST_DIV_ZERO = 3'd3;
    localparam logic [2:0] ST_NOT_BOOL = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

endpackage

>>> hw/rtl/rpn_stack_evaluator.sv
// Channel | Direction | Handshake                 | Payload
// in      | request   | i_in_valid / o_in_stall   | i_mode, i_literal
// out     | result    | o_out_valid / i_out_stall | o_status, o_shown_*, o_depth
//
// One request at a time. A simple operation passes from accept to result through two
// registered stack memory reads, execute and output load; swap adds a second write state.
// Multiply, divide and modulo iterate before the write-back: the shared shift/add-subtract
// unit retires one bit per cycle. A new request is taken while a result waits in the
// output register. Synchronous active-low reset empties the stack; the memory itself
// is not cleared. A stalled result holds the output register; a finished result behind
// it waits in idle and holds o_in_stall high until the register frees up.
module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int unsigned WORD_WIDTH  = WORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [4:0]  i_mode,
    input  logic [31:0] i_literal,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_shown_valid,
    output logic [31:0] o_shown_value,
    output logic        o_shown_is_bool,
    output logic [6:0]  o_depth
);

    localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned CW  = $clog2(WORD_WIDTH);
    localparam int unsigned W   = WORD_WIDTH;

    typedef struct packed {
        logic         tag;
        logic [W-1:0] val;
    } t_entry;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RDA   = 7'b0000010,
        S_RDB   = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_ITER  = 7'b0010000,
        S_DONEM = 7'b0100000,
        S_WR2   = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic             r_out_pend, n_out_pend;
    logic [SPW-1:0]   r_sp, n_sp;
    logic [4:0]       r_mode;
    logic [63:0]      r_lit64;
    t_entry           r_mem [STACK_DEPTH];
    t_entry           r_rd;
    t_entry           r_a, r_b;
    logic [2:0]       r_status, n_status;
    logic             r_shv, n_shv;
    logic             r_shb, n_shb;
    logic [31:0]      r_shval, n_shval;
    logic [W-1:0]     r_acc, r_mq, r_md;
    logic [CW-1:0]    r_cnt;

    logic             in_acc, out_acc, slot_free, go_iter;
    logic             w_en;
    logic [AW-1:0]    w_addr, rd_addr;
    t_entry           w_data;
    logic [SPW-1:0]   sp_m1, sp_m2;
    logic [AW-1:0]    idx_top, idx_nxt, idx_sp;
    logic             sp0, sp1, full;
    logic [W-1:0]     a_val, b_val, mag_a, mag_b, res, mul_res, dq;
    logic             cmp;
    logic [W:0]       shifted, diff;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = o_out_valid && !i_out_stall;
    // stall input while busy or while a previous result has not reached the output register
    assign o_in_stall = (r_state != S_IDLE) || r_out_pend;
    assign slot_free  = !o_out_valid || !i_out_stall;

    assign sp_m1   = r_sp - SPW'(1);
    assign sp_m2   = r_sp - SPW'(2);
    assign idx_top = sp_m1[AW-1:0];
    assign idx_nxt = sp_m2[AW-1:0];
    assign idx_sp  = r_sp[AW-1:0];
    assign sp0     = (r_sp == '0);
    assign sp1     = (r_sp == SPW'(1));
    assign full    = (r_sp == SPW'(STACK_DEPTH));

    assign a_val = r_a.val;
    assign b_val = r_b.val;
    assign mag_a = a_val[W-1] ? (W'(0) - a_val) : a_val;
    assign mag_b = b_val[W-1] ? (W'(0) - b_val) : b_val;

    assign shifted = {r_acc, r_mq[W-1]};
    assign diff    = shifted - {1'b0, r_md};

    assign rd_addr = (r_state == S_RDA) ? idx_nxt : idx_top;

    // stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // left operand b, right operand a
    always_comb begin
        unique case (r_mode)
            MD_LT:   cmp = $signed(b_val) <  $signed(a_val);
            MD_LE:   cmp = $signed(b_val) <= $signed(a_val);
            MD_GT:   cmp = $signed(b_val) >  $signed(a_val);
            MD_GE:   cmp = $signed(b_val) >= $signed(a_val);
            default: cmp = (b_val == a_val);
        endcase
    end

    assign mul_res = r_acc;
    always_comb begin
        if (r_mode == MD_DIV) begin
            dq = (a_val[W-1] ^ b_val[W-1]) ? (W'(0) - r_mq) : r_mq;
        end else if (r_mode == MD_MOD) begin
            dq = b_val[W-1] ? (W'(0) - r_acc) : r_acc;
        end else begin
            dq = mul_res;
        end
    end

    assign res = (r_mode == MD_ADD) ? (b_val + a_val) : (b_val - a_val);

    always_comb begin
        n_state    = r_state;
        n_sp       = r_sp;
        n_status   = r_status;
        n_shv      = r_shv;
        n_shb      = r_shb;
        n_shval    = r_shval;
        n_out_pend = r_out_pend;
        w_en       = 1'b0;
        w_addr     = idx_nxt;
        w_data     = r_a;
        go_iter    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: n_state = S_RDB;
            S_RDB: n_state = S_EXEC;
            S_EXEC: begin
                n_status   = ST_OK;
                n_shv      = 1'b0;
                n_shb      = 1'b0;
                n_shval    = '0;
                n_out_pend = 1'b1;
                n_state    = S_IDLE;
                case (r_mode) inside
                    MD_PUSH_INT, MD_TRUE, MD_FALSE: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_en   = 1'b1;
                            w_addr = idx_sp;
                            if (r_mode == MD_PUSH_INT) begin
                                w_data = '{tag: 1'b0, val: r_lit64[W-1:0]};
                            end else begin
                                w_data = '{tag: 1'b1, val: W'(r_mode == MD_TRUE)};
                            end
                            n_sp = r_sp + SPW'(1);
                        end
                    end
                    MD_PRINT: begin
                        if (sp0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_shv   = 1'b1;
                            n_shb   = r_a.tag;
                            n_shval = 32'(a_val);
                        end
                    end
                    MD_CLEAR: n_sp = '0;
                    MD_DROP: begin
                        if (sp0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_sp = sp_m1;
                        end
                    end
                    MD_DUP: begin
                        if (sp0) begin
                            n_status = ST_EMPTY;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_en   = 1'b1;
                            w_addr = idx_sp;
                            n_sp   = r_sp + SPW'(1);
                        end
                    end
                    MD_SWAP: begin
                        if (sp0 || sp1) begin
                            n_status = ST_EMPTY;
                            n_sp     = '0;
                        end else begin
                            w_en       = 1'b1;
                            n_out_pend = 1'b0;
                            n_state    = S_WR2;
                        end
                    end
                    MD_NOT: begin
                        if (sp0) begin
                            n_status = ST_EMPTY;
                        end else if (!r_a.tag) begin
                            n_status = ST_NOT_BOOL;
                            n_sp     = sp_m1;
                        end else begin
                            w_en   = 1'b1;
                            w_addr = idx_top;
                            w_data = '{tag: 1'b1, val: W'(a_val == '0)};
                        end
                    end
                    [MD_ADD:MD_EQ]: begin
                        if (sp0 || sp1) begin
                            n_status = ST_EMPTY;
                            n_sp     = '0;
                        end else if (r_a.tag || r_b.tag) begin
                            n_status = ST_NOT_INT;
                            n_sp     = sp_m2;
                        end else if ((r_mode == MD_DIV || r_mode == MD_MOD)
                                     && a_val == '0) begin
                            n_status = ST_DIV_ZERO;
                            n_sp     = sp_m2;
                        end else if (r_mode == MD_MUL || r_mode == MD_DIV
                                     || r_mode == MD_MOD) begin
                            go_iter    = 1'b1;
                            n_out_pend = 1'b0;
                            n_state    = S_ITER;
                        end else if (r_mode == MD_ADD || r_mode == MD_SUB) begin
                            w_en   = 1'b1;
                            w_data = '{tag: 1'b0, val: res};
                            n_sp   = sp_m1;
                        end else begin
                            w_en   = 1'b1;
                            w_data = '{tag: 1'b1, val: W'(cmp)};
                            n_sp   = sp_m1;
                        end
                    end
                    default: ;
                endcase
            end
            S_ITER: begin
                if (r_cnt == CW'(W - 1)) begin
                    n_state = S_DONEM;
                end
            end
            S_DONEM: begin
                w_en       = 1'b1;
                w_data     = '{tag: 1'b0, val: dq};
                n_sp       = sp_m1;
                n_out_pend = 1'b1;
                n_state    = S_IDLE;
            end
            S_WR2: begin
                w_en       = 1'b1;
                w_addr     = idx_top;
                w_data     = r_b;
                n_out_pend = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // hold a finished result until the output register frees up
        if (r_out_pend && slot_free && r_state == S_IDLE) begin
            n_out_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_pend  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sp       <= n_sp;
            r_out_pend <= n_out_pend;
            if (r_out_pend && slot_free && r_state == S_IDLE) begin
                o_out_valid <= 1'b1;
            end else if (out_acc) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_shv    <= n_shv;
        r_shb    <= n_shb;
        r_shval  <= n_shval;
        if (in_acc) begin
            r_mode  <= i_mode;
            r_lit64 <= {{32{i_literal[31]}}, i_literal};
        end
        if (r_state == S_RDA) begin
            r_a <= r_rd;
        end
        if (r_state == S_RDB) begin
            r_b <= r_rd;
        end
        if (r_out_pend && slot_free && r_state == S_IDLE) begin
            o_status        <= r_status;
            o_shown_valid   <= r_shv;
            o_shown_is_bool <= r_shb;
            o_shown_value   <= r_shval;
            o_depth         <= 7'(r_sp);
        end
    end

    // shared shift/add-subtract unit: multiply low word, or restoring divide
    always_ff @(posedge i_clk) begin
        if (go_iter) begin
            r_acc <= '0;
            r_cnt <= '0;
            if (r_mode == MD_MUL) begin
                r_mq <= a_val;
                r_md <= b_val;
            end else begin
                r_mq <= mag_b;
                r_md <= mag_a;
            end
        end else if (r_state == S_ITER) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_mode == MD_MUL) begin
                if (r_mq[0]) begin
                    r_acc <= r_acc + r_md;
                end
                r_md <= r_md << 1;
                r_mq <= r_mq >> 1;
            end else if (!diff[W]) begin
                r_acc <= diff[W-1:0];
                r_mq  <= {r_mq[W-2:0], 1'b1};
            end else begin
                r_acc <= shifted[W-1:0];
                r_mq  <= {r_mq[W-2:0], 1'b0};
            end
        end
    end

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |-> (r_state == S_EXEC || r_state == S_WR2 || r_state == S_DONEM))
        else $error("memory write outside execute states");

    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_pend && slot_free && r_state == S_IDLE) |=> o_out_valid)
        else $error("pending result not loaded");

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_out_pend) |=> (r_state == S_RDA))
        else $error("accepted request did not start reading");

endmodule
